// ----- rtl/cpfsk_pkg.sv -----
// Shared constants, register indexes and the sine table generator for the
// continuous phase FSK modulator. No dependencies.
package cpfsk_pkg;

   localparam int PHASE_BITS_DEFAULT      = 32;
   localparam int SINE_TABLE_BITS_DEFAULT = 10;
   localparam int SAMPLE_BITS_DEFAULT     = 16;

   localparam int STEP_BITS      = 32;
   localparam int AMP_BITS       = 16;
   localparam int COUNT_BITS     = 16;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 8;

   localparam logic [AMP_BITS-1:0]   AMPLITUDE_RESET       = AMP_BITS'(32768);
   localparam logic [COUNT_BITS-1:0] SAMPLES_PER_BIT_RESET = COUNT_BITS'(441);

   // 2*pi in Q30.
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] Q30_ONE    = 64'd1 << 30;

   // The Taylor divisors (2j)(2j+1) are applied as reciprocals rounded up. With
   // dividends below 2^32 and divisors below 2^9 this shift keeps every quotient
   // exact.
   localparam int          RECIP_SHIFT = 41;
   localparam logic [63:0] RECIP_6     = ((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6;
   localparam logic [63:0] RECIP_20    = ((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20;
   localparam logic [63:0] RECIP_42    = ((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42;
   localparam logic [63:0] RECIP_72    = ((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72;
   localparam logic [63:0] RECIP_110   = ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110;
   localparam logic [63:0] RECIP_156   = ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156;
   localparam logic [63:0] RECIP_210   = ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210;
   localparam logic [63:0] RECIP_272   = ((64'd1 << RECIP_SHIFT) + 64'd271) / 64'd272;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PHASE_STEP_ZERO = CSR_INDEX_BITS'(0),
      REG_PHASE_STEP_ONE  = CSR_INDEX_BITS'(1),
      REG_AMPLITUDE       = CSR_INDEX_BITS'(2),
      REG_SAMPLES_PER_BIT = CSR_INDEX_BITS'(3)
   } csr_index_type;

   function automatic logic [63:0] taylor_recip(input int j);
      case (j)
         1:       return RECIP_6;
         2:       return RECIP_20;
         3:       return RECIP_42;
         4:       return RECIP_72;
         5:       return RECIP_110;
         6:       return RECIP_156;
         7:       return RECIP_210;
         default: return RECIP_272;
      endcase
   endfunction

   // Table entry k: round(scale * sin(2*pi*k/2^tbits)), built from a Q30
   // Taylor series over one quarter wave and folded by quadrant. Only used
   // at elaboration to build the constant ROM contents.
   function automatic logic signed [63:0] sine_entry(input int k, input int tbits,
                                                    input int sbits);
      logic [63:0]  qsize;
      logic [63:0]  quad;
      logic [63:0]  r;
      logic [63:0]  m;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [127:0] wide;
      logic [63:0]  sub;
      logic [63:0]  s;
      logic [63:0]  scale;
      logic [63:0]  v;
      qsize = 64'd1 << (tbits - 2);
      quad  = (64'(k) >> (tbits - 2)) & 64'd3;
      r     = 64'(k) & (qsize - 64'd1);
      m     = quad[0] ? (qsize - r) : r;
      x     = (TWO_PI_Q30 * m) >> tbits;
      x2    = (x * x) >> 30;
      t     = Q30_ONE;
      scale = (64'd1 << (sbits - 1)) - 64'd1;
      for (int j = 8; j >= 1; j--) begin
         wide = {64'd0, (x2 * t) >> 30} * {64'd0, taylor_recip(j)};
         sub  = wide[RECIP_SHIFT+63:RECIP_SHIFT];
         t    = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
      end
      s = (x * t) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      v = (s * scale + (Q30_ONE >> 1)) >> 30;
      return quad[1] ? -$signed(v) : $signed(v);
   endfunction

endpackage

// ----- rtl/cpfsk_sine_rom.sv -----
// Synchronous-read sine ROM for the FSK modulator, contents built at
// elaboration. Depends on cpfsk_pkg.
module cpfsk_sine_rom
   import cpfsk_pkg::*;
#(
   parameter int TABLE_BITS  = SINE_TABLE_BITS_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [TABLE_BITS-1:0]         addr,
   output logic signed [SAMPLE_BITS-1:0] data
);

   localparam int DEPTH = 1 << TABLE_BITS;

   logic signed [SAMPLE_BITS-1:0] rom_w [DEPTH];
   logic signed [SAMPLE_BITS-1:0] data_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_entry
      localparam logic signed [63:0] ENTRY = sine_entry(k, TABLE_BITS, SAMPLE_BITS);
      assign rom_w[k] = ENTRY[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= rom_w[addr];
      end
   end

   assign data = data_ff;

endmodule

// ----- rtl/continuous_phase_fsk_modulator_unit.sv -----
// Top level of the binary continuous phase FSK modulator.
// Depends on cpfsk_pkg and cpfsk_sine_rom.
//
// Each req_ transaction is one sample tick carrying the message bit. The block
// returns one rsp_ transaction per tick: the sine of the phase held before the
// tick, scaled by the amplitude register, and a flag on the last sample of each
// bit period. The phase accumulator and the sample counter update in the cycle
// the tick is accepted, so a new tick is taken every cycle while rsp_ready does
// not stall the pipeline; the ROM read is registered at the accepting edge and
// the amplitude multiply feeds the result register once that register is free.
// No clearing is needed after reset. The user must write registers through the
// csr_ port only while no tick is in flight; the block does not enforce this.
module continuous_phase_fsk_modulator_unit
   import cpfsk_pkg::*;
#(
   parameter int PHASE_BITS      = PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEFAULT,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_write,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_tx_bit,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_bit_done
);

   logic [STEP_BITS-1:0]  step_zero_ff;
   logic [STEP_BITS-1:0]  step_one_ff;
   logic [AMP_BITS-1:0]   amplitude_ff;
   logic [COUNT_BITS-1:0] samples_per_bit_ff;

   logic [PHASE_BITS-1:0] phase_acc_ff, phase_acc_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  s1_valid_ff, s1_done_ff;
   logic                  rsp_valid_ff, rsp_done_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;

   logic                          accept;
   logic                          out_en;
   logic                          s1_en;
   logic                          done_in;
   logic [COUNT_BITS:0]           count_plus;
   logic [STEP_BITS-1:0]          step_sel;
   logic [PHASE_BITS+STEP_BITS-1:0] step_wide;
   logic signed [SAMPLE_BITS-1:0] rom_data;
   logic signed [SAMPLE_BITS+AMP_BITS:0] product;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_zero_ff       <= '0;
         step_one_ff        <= '0;
         amplitude_ff       <= AMPLITUDE_RESET;
         samples_per_bit_ff <= SAMPLES_PER_BIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_PHASE_STEP_ZERO: step_zero_ff       <= csr_wdata[STEP_BITS-1:0];
            REG_PHASE_STEP_ONE:  step_one_ff        <= csr_wdata[STEP_BITS-1:0];
            REG_AMPLITUDE:       amplitude_ff       <= csr_wdata[AMP_BITS-1:0];
            REG_SAMPLES_PER_BIT: samples_per_bit_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Stage one may take a new transaction when empty or when it drains into
   // the output register.
   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign s1_en     = !s1_valid_ff || out_en;
   assign req_ready = s1_en;
   assign accept    = req_valid && s1_en;

   always_comb begin
      step_sel     = req_tx_bit ? step_one_ff : step_zero_ff;
      step_wide    = {{PHASE_BITS{1'b0}}, step_sel};
      phase_acc_in = phase_acc_ff + step_wide[PHASE_BITS-1:0];
      count_plus   = {1'b0, count_ff} + (COUNT_BITS+1)'(1);
      // A period of zero behaves as one; lowering the period below the count
      // ends the current bit on the next sample.
      done_in      = count_plus >= {1'b0, samples_per_bit_ff};
      count_in     = done_in ? '0 : count_plus[COUNT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         count_ff     <= '0;
      end else if (accept) begin
         phase_acc_ff <= phase_acc_in;
         count_ff     <= count_in;
      end
   end

   cpfsk_sine_rom #(
      .TABLE_BITS  (SINE_TABLE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_rom (
      .clock  (clock),
      .enable (accept),
      .addr   (phase_acc_ff[PHASE_BITS-1 -: SINE_TABLE_BITS]),
      .data   (rom_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_done_ff <= done_in;
      end
   end

   // Arithmetic shift right by the amplitude width rounds toward minus infinity.
   assign product       = rom_data * $signed({1'b0, amplitude_ff});
   assign rsp_sample_in = product[SAMPLE_BITS+AMP_BITS-1:AMP_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s1_valid_ff) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_done_ff   <= s1_done_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sample   = rsp_sample_ff;
   assign rsp_bit_done = rsp_done_ff;

endmodule
